// ===== rtl/trgr_pkg.sv =====
// Package for the thin row gap repair core: result type, queue sizing and
// the per-column repair function. No dependencies.
`default_nettype none

package trgr_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned QueueDepth = 3;
  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    pix_t pixel;
    logic done;
  } result_t;

  function automatic pix_t pmin(input pix_t a, input pix_t b);
    pmin = (a < b) ? a : b;
  endfunction

  function automatic pix_t pmax(input pix_t a, input pix_t b);
    pmax = (a > b) ? a : b;
  endfunction

  // Max of the center and the three bridging terms (left, right, straight).
  function automatic pix_t repair(input pix_t ul, input pix_t uc, input pix_t ur,
                                  input pix_t dl, input pix_t dc, input pix_t dr,
                                  input pix_t c);
    pix_t v;
    v = c;
    v = pmax(v, pmin(ul, pmax(dc, dr)));
    v = pmax(v, pmin(ur, pmax(dc, dl)));
    v = pmax(v, pmin(uc, pmax(pmax(dl, dc), dr)));
    repair = v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/trgr_result_queue.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on trgr_pkg.
`default_nettype none

module trgr_result_queue (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [1:0]                     push_cnt_i,
  input  wire trgr_pkg::result_t              wdata0_i,
  input  wire trgr_pkg::result_t              wdata1_i,
  input  wire logic                           pop_i,
  output trgr_pkg::result_t                   head_o,
  output logic [trgr_pkg::CountW-1:0]         count_o
);

  localparam int unsigned Depth = trgr_pkg::QueueDepth;
  localparam int unsigned CntW  = trgr_pkg::CountW;

  trgr_pkg::result_t ent_q [Depth];
  trgr_pkg::result_t ent_d [Depth];
  logic [CntW-1:0]   count_q, count_d, base;

  always_comb begin
    base = count_q - CntW'(pop_i);
    for (int i = 0; i < Depth; i++) begin
      // shift down on pop
      if (pop_i && (i + 1 < Depth)) begin
        ent_d[i] = ent_q[(i + 1) % Depth];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if (push_cnt_i != 2'd0 && base == CntW'(i)) begin
        ent_d[i] = wdata0_i;
      end
      if (push_cnt_i == 2'd2 && base + CntW'(1) == CntW'(i)) begin
        ent_d[i] = wdata1_i;
      end
    end
    count_d = base + CntW'(push_cnt_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign head_o  = ent_q[0];
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/thin_row_gap_repair_core.sv =====
// Thin row gap repair core: top level. Streams pixel columns in, repaired
// pixels out. Depends on trgr_pkg and trgr_result_queue.
`default_nettype none

// Takes one column per cycle (above, center, below pixel and a row-end mark)
// and returns one repaired pixel per column, in column order. Each result is
// the max of the center pixel and three min/max bridging terms over the
// 3x3 neighborhood; pixels outside the row read as 0. A column's result
// needs its right neighbor, so output lags one column; in a row of two or
// more columns the row-end column releases two results (the held column and
// itself, the latter flagged with row_done). A request is taken whenever the
// result queue holds at most one result, so the core sustains one column per
// cycle; it stalls after the end of a row of two or more columns, while the
// extra result drains, and whenever the downstream side holds back. The
// results a request releases can be taken in the cycle after that request.
module thin_row_gap_repair_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] above_pixel_i,
  input  wire logic [7:0] center_pixel_i,
  input  wire logic [7:0] below_pixel_i,
  input  wire logic       row_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      repaired_pixel_o,
  output logic            row_done_o
);

  // Column window state.
  trgr_pkg::pix_t prev_above_q, prev_above_d;
  trgr_pkg::pix_t prev_below_q, prev_below_d;
  trgr_pkg::pix_t held_above_q, held_above_d;
  trgr_pkg::pix_t held_center_q, held_center_d;
  trgr_pkg::pix_t held_below_q, held_below_d;
  logic           column_held_q, column_held_d;

  logic                          accept, pop;
  logic [1:0]                    push_cnt;
  trgr_pkg::result_t             res_held, res_last, wdata0, wdata1, head;
  trgr_pkg::pix_t                left_above, left_below;
  logic [trgr_pkg::CountW-1:0]   q_count;

  // Room for two results after this cycle's worst case.
  assign in_ready_o = (q_count <= trgr_pkg::CountW'(1));
  assign accept     = in_valid_i & in_ready_o;
  assign pop        = out_valid_o & out_ready_i;

  always_comb begin
    // Held column, its right neighbor is the incoming column.
    res_held.pixel = trgr_pkg::repair(prev_above_q, held_above_q, above_pixel_i,
                                      prev_below_q, held_below_q, below_pixel_i,
                                      held_center_q);
    res_held.done  = 1'b0;

    // Incoming column as the row's last: right neighbor is outside the row.
    left_above = column_held_q ? held_above_q : '0;
    left_below = column_held_q ? held_below_q : '0;
    res_last.pixel = trgr_pkg::repair(left_above, above_pixel_i, '0,
                                      left_below, below_pixel_i, '0,
                                      center_pixel_i);
    res_last.done  = 1'b1;

    push_cnt = 2'd0;
    wdata0   = res_held;
    wdata1   = res_last;
    if (accept) begin
      if (column_held_q) begin
        push_cnt = row_end_i ? 2'd2 : 2'd1;
      end else begin
        wdata0   = res_last;
        push_cnt = row_end_i ? 2'd1 : 2'd0;
      end
    end

    // Advance the window; drop it all at the row end.
    prev_above_d  = prev_above_q;
    prev_below_d  = prev_below_q;
    held_above_d  = held_above_q;
    held_center_d = held_center_q;
    held_below_d  = held_below_q;
    column_held_d = column_held_q;
    if (accept) begin
      if (row_end_i) begin
        prev_above_d  = '0;
        prev_below_d  = '0;
        held_above_d  = '0;
        held_center_d = '0;
        held_below_d  = '0;
        column_held_d = 1'b0;
      end else begin
        prev_above_d  = left_above;
        prev_below_d  = left_below;
        held_above_d  = above_pixel_i;
        held_center_d = center_pixel_i;
        held_below_d  = below_pixel_i;
        column_held_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_above_q  <= '0;
      prev_below_q  <= '0;
      held_above_q  <= '0;
      held_center_q <= '0;
      held_below_q  <= '0;
      column_held_q <= 1'b0;
    end else begin
      prev_above_q  <= prev_above_d;
      prev_below_q  <= prev_below_d;
      held_above_q  <= held_above_d;
      held_center_q <= held_center_d;
      held_below_q  <= held_below_d;
      column_held_q <= column_held_d;
    end
  end

  trgr_result_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .wdata0_i   (wdata0),
    .wdata1_i   (wdata1),
    .pop_i      (pop),
    .head_o     (head),
    .count_o    (q_count)
  );

  assign out_valid_o      = (q_count != '0);
  assign repaired_pixel_o = head.pixel;
  assign row_done_o       = head.done;

endmodule

`default_nettype wire
